// ----- design/hkd_pkg.sv -----
// shared types and constants for the hid report key event diff block
package hkd_pkg;

   localparam int KEY_SLOTS_DEF = 6;
   localparam int IN_SLOTS      = 6;
   localparam int KEY_W         = 8;
   localparam int QUEUE_DEPTH   = 2;

   typedef logic [KEY_W-1:0] key_type;

   typedef enum logic {
      EVT_DOWN = 1'b0,
      EVT_UP   = 1'b1
   } evt_kind_type;

endpackage

// ----- design/hkd_if.sv -----
// valid/ready channel interfaces for reports and key events
interface hkd_req_if;
   import hkd_pkg::*;
   logic    valid;
   logic    ready;
   logic    report_ok;
   key_type key_slot_0;
   key_type key_slot_1;
   key_type key_slot_2;
   key_type key_slot_3;
   key_type key_slot_4;
   key_type key_slot_5;

   modport source (
      output valid, report_ok, key_slot_0, key_slot_1, key_slot_2,
             key_slot_3, key_slot_4, key_slot_5,
      input  ready
   );
   modport sink (
      input  valid, report_ok, key_slot_0, key_slot_1, key_slot_2,
             key_slot_3, key_slot_4, key_slot_5,
      output ready
   );
endinterface

interface hkd_rsp_if;
   import hkd_pkg::*;
   logic    valid;
   logic    ready;
   logic    event_kind;
   key_type key_code;
   logic    last_event;

   modport source (
      output valid, event_kind, key_code, last_event,
      input  ready
   );
   modport sink (
      input  valid, event_kind, key_code, last_event,
      output ready
   );
endinterface

// ----- design/hkd_front.sv -----
// front end: compares each report with the held keys and queues an event job
module hkd_front #(
   parameter int KEY_SLOTS = hkd_pkg::KEY_SLOTS_DEF,
   parameter int JOB_W     = 2 * KEY_SLOTS * (hkd_pkg::KEY_W + 1)
) (
   input  logic             clock,
   input  logic             reset,
   hkd_req_if.sink          req,
   output logic             push_valid,
   output logic [JOB_W-1:0] push_data,
   input  logic             push_ready
);
   import hkd_pkg::*;

   localparam int CNT_W = $clog2(KEY_SLOTS + 1);

   key_type                       held_ff [KEY_SLOTS];
   key_type                       held_in [KEY_SLOTS];
   key_type                       slot_all [IN_SLOTS];
   key_type                       now_key [KEY_SLOTS];
   logic    [CNT_W-1:0]           pos [KEY_SLOTS];
   logic    [KEY_SLOTS-1:0]       down_mask;
   logic    [KEY_SLOTS-1:0]       up_mask;
   logic    [2*KEY_SLOTS-1:0][KEY_W-1:0] job_codes;
   logic                          accept;
   logic                          hit;

   assign slot_all[0] = req.key_slot_0;
   assign slot_all[1] = req.key_slot_1;
   assign slot_all[2] = req.key_slot_2;
   assign slot_all[3] = req.key_slot_3;
   assign slot_all[4] = req.key_slot_4;
   assign slot_all[5] = req.key_slot_5;

   always_comb begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
         now_key[i] = slot_all[i];
      end
   end

   // key-down per new slot, key-up per held entry
   always_comb begin
      down_mask = '0;
      up_mask   = '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         hit = 1'b0;
         for (int j = 0; j < KEY_SLOTS; j++) begin
            if (held_ff[j] != '0 && held_ff[j] == now_key[i]) hit = 1'b1;
         end
         down_mask[i] = (now_key[i] != '0) && !hit;
         hit = 1'b0;
         for (int j = 0; j < KEY_SLOTS; j++) begin
            if (now_key[j] != '0 && now_key[j] == held_ff[i]) hit = 1'b1;
         end
         up_mask[i] = (held_ff[i] != '0) && !hit;
      end
   end

   // compaction of the nonzero new keys
   always_comb begin
      pos[0] = '0;
      for (int i = 1; i < KEY_SLOTS; i++) begin
         pos[i] = pos[i-1] + CNT_W'(now_key[i-1] != '0);
      end
      for (int j = 0; j < KEY_SLOTS; j++) begin
         held_in[j] = '0;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            if (now_key[i] != '0 && pos[i] == CNT_W'(j)) held_in[j] = now_key[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
         job_codes[i]             = now_key[i];
         job_codes[KEY_SLOTS + i] = held_ff[i];
      end
   end

   assign req.ready  = push_ready;
   assign accept     = req.valid && push_ready;
   assign push_valid = accept && req.report_ok && ((down_mask != '0) || (up_mask != '0));
   assign push_data  = {job_codes, up_mask, down_mask};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_SLOTS; i++) held_ff[i] <= '0;
      end else if (accept && req.report_ok) begin
         held_ff <= held_in;
      end
   end

endmodule

// ----- design/hkd_queue.sv -----
// small job queue between the front and back ends
module hkd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = hkd_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[head_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      if (pop)  head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[tail_ff] <= in_data;
   end

endmodule

// ----- design/hkd_back.sv -----
// back end: walks a job's event mask and sends one event per beat
module hkd_back #(
   parameter int KEY_SLOTS = hkd_pkg::KEY_SLOTS_DEF,
   parameter int JOB_W     = 2 * KEY_SLOTS * (hkd_pkg::KEY_W + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  logic [JOB_W-1:0] pop_data,
   hkd_rsp_if.source        rsp
);
   import hkd_pkg::*;

   localparam int EV_N = 2 * KEY_SLOTS;

   logic [EV_N-1:0]             mask_ff, mask_in;
   logic [EV_N-1:0][KEY_W-1:0]  codes_ff;
   logic [EV_N-1:0]             lowest;
   logic [EV_N-1:0]             new_mask;
   logic [EV_N-1:0][KEY_W-1:0]  new_codes;
   key_type                     sel_code;
   logic                        is_last;
   logic                        emit;
   logic                        load;
   logic                        rsp_valid_ff;
   evt_kind_type                kind_ff, kind_in;
   key_type                     code_ff;
   logic                        last_ff;

   assign {new_codes, new_mask} = pop_data;

   // lowest set bit first: key-downs in slot order, then key-ups in held order
   assign lowest  = mask_ff & (~mask_ff + 1'b1);
   assign is_last = ((mask_ff & ~lowest) == '0);
   assign kind_in = (lowest[EV_N-1:KEY_SLOTS] != '0) ? EVT_UP : EVT_DOWN;

   always_comb begin
      sel_code = '0;
      for (int i = 0; i < EV_N; i++) begin
         if (lowest[i]) sel_code = sel_code | codes_ff[i];
      end
   end

   assign emit      = (mask_ff != '0) && (!rsp_valid_ff || rsp.ready);
   assign pop_ready = (mask_ff == '0) || (emit && is_last);
   assign load      = pop_valid && pop_ready;

   always_comb begin
      mask_in = mask_ff;
      if (load)      mask_in = new_mask;
      else if (emit) mask_in = mask_ff & ~lowest;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff <= mask_in;
         if (emit)           rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) codes_ff <= new_codes;
      if (emit) begin
         kind_ff <= kind_in;
         code_ff <= sel_code;
         last_ff <= is_last;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.event_kind = kind_ff;
   assign rsp.key_code   = code_ff;
   assign rsp.last_event = last_ff;

endmodule

// ----- design/hid_report_key_event_diff_unit.sv -----
// top level of the hid report key event diff block
// A report is taken whenever the job queue has room; it is compared against
// the held keys at once, an ok report updates the held keys, and a report
// that changes anything queues one job. The back end sends that job's
// events one per cycle while the event output is not stalled, key-downs in
// slot order and then key-ups in held order, with last_event on the final
// one; a report with N changes gives N events (at most 2*KEY_SLOTS, 12 by
// default), and reports that are not ok or change nothing give no events.
// The two-entry job queue lets new reports come in while earlier events still drain.
module hid_report_key_event_diff_unit #(
   parameter int KEY_SLOTS = hkd_pkg::KEY_SLOTS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   hkd_req_if.sink   req,
   hkd_rsp_if.source rsp
);
   import hkd_pkg::*;

   localparam int JOB_W = 2 * KEY_SLOTS * (KEY_W + 1);

   logic             push_valid;
   logic             push_ready;
   logic [JOB_W-1:0] push_data;
   logic             pop_valid;
   logic             pop_ready;
   logic [JOB_W-1:0] pop_data;

   hkd_front #(
      .KEY_SLOTS (KEY_SLOTS),
      .JOB_W     (JOB_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   hkd_queue #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   hkd_back #(
      .KEY_SLOTS (KEY_SLOTS),
      .JOB_W     (JOB_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp)
   );

endmodule

// ----- design/hkd_checker.sv -----
// port-level checks for the hid report key event diff block
module hkd_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_event_kind,
   input hkd_pkg::key_type  rsp_key_code,
   input logic              rsp_last_event
);
   import hkd_pkg::*;

   logic in_up_ff;

   // inside a report's key-up run until its last beat
   always_ff @(posedge clock) begin
      if (reset) begin
         in_up_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         in_up_ff <= (rsp_event_kind == EVT_UP) && !rsp_last_event;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("event beat right after reset");

   a_code_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_key_code != '0)
      else $error("event beat with empty key code");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_key_code)
         && $stable(rsp_event_kind) && $stable(rsp_last_event))
      else $error("stalled event beat changed");

   a_up_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && in_up_ff |-> rsp_event_kind == EVT_UP)
      else $error("key-down inside a report's key-up run");

endmodule

bind hid_report_key_event_diff_unit hkd_checker u_hkd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_event_kind (rsp.event_kind),
   .rsp_key_code   (rsp.key_code),
   .rsp_last_event (rsp.last_event)
);
